/* rtl/core/stlim_pkg.sv */
// Shared types, constants and the tanh table generator for the stereo soft limiter.
`timescale 1ns / 1ps

package stlim_pkg;

   localparam int unsigned NUM_LANES    = 2;
   localparam int unsigned NUM_STAGES   = 8;
   localparam int unsigned LANE_STAGES  = NUM_STAGES - 1;

   localparam int unsigned SAMPLE_IN_W  = 18;
   localparam int unsigned SAMPLE_OUT_W = 16;
   localparam int unsigned THR_W        = 15;
   localparam int unsigned GAIN_W       = 16;
   localparam int unsigned ROM_W        = 16;
   localparam int unsigned FRAC_W       = 18;
   localparam int unsigned GAIN_FRAC_W  = 12;
   localparam int unsigned CSR_IDX_W    = 4;
   localparam int unsigned CSR_DATA_W   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_KNEE_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KNEE_GAIN      = 4'd1;

   localparam logic [THR_W-1:0]  THR_RESET  = 15'd27886;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd27492;

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   typedef logic [LANE_STAGES-1:0] stage_en_type;

   // restoring long division, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         if (r >= den) begin
            r    = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(-y), y in Q30: short series on y/256, then squared eight times
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] y);
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] z3;
      logic [63:0] z4;
      logic [63:0] e;
      z  = y >> 8;
      z2 = (z * z) >> 30;
      z3 = (z2 * z) >> 30;
      z4 = (z2 * z2) >> 30;
      e  = Q30_ONE + (z2 >> 1) + udiv64(z4, 64'd24) - z - udiv64(z3, 64'd6);
      for (int s = 0; s < 8; s++) begin
         e = (e * e + (64'd1 << 29)) >> 30;
      end
      return e;
   endfunction

   // tanh(8k/n) in Q15, before the monotonic fix-up
   function automatic logic [ROM_W-1:0] tanh_point(input logic [63:0] k, input logic [63:0] n);
      logic [63:0] y;
      logic [63:0] e;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] t;
      y = udiv64((64'd16 * k) << 30, n);
      e = exp_neg_q30(y);
      if (e > Q30_ONE) begin
         e = Q30_ONE;
      end
      num = (Q30_ONE - e) << 15;
      den = Q30_ONE + e;
      t   = udiv64(num + (den >> 1), den);
      if (t > 64'd32768) begin
         t = 64'd32768;
      end
      return t[ROM_W-1:0];
   endfunction

endpackage

/* rtl/core/stlim_lane.sv */
// One channel of the soft limiter: knee test, gain, table lookup and interpolation.
`timescale 1ns / 1ps

module stlim_lane import stlim_pkg::*; #(
   parameter int unsigned TANH_TABLE_ENTRIES = 256
) (
   input  logic                           clock,
   input  stage_en_type                   stage_en,
   input  logic        [THR_W-1:0]        knee_threshold,
   input  logic        [GAIN_W-1:0]       knee_gain,
   input  logic signed [SAMPLE_IN_W-1:0]  sample_in,
   output logic signed [SAMPLE_OUT_W-1:0] sample_out,
   output logic                           limited
);

   localparam int unsigned AW     = $clog2(TANH_TABLE_ENTRIES + 1);
   localparam int unsigned MAG_W  = SAMPLE_IN_W;
   localparam int unsigned PROD_W = MAG_W + GAIN_W;
   localparam int unsigned ARG_W  = PROD_W - GAIN_FRAC_W;
   localparam int unsigned P_W    = ARG_W + AW;
   localparam int unsigned IDX_W  = P_W - FRAC_W;
   localparam int unsigned IP_W   = ROM_W + FRAC_W;

   typedef logic [ROM_W-1:0] rom_type [0:TANH_TABLE_ENTRIES];

   function automatic rom_type build_rom();
      rom_type            r;
      logic [ROM_W-1:0]   t;
      for (int k = 0; k <= int'(TANH_TABLE_ENTRIES); k++) begin
         t = tanh_point(64'(k), 64'(TANH_TABLE_ENTRIES));
         if (k > 0 && t < r[k-1]) begin
            t = r[k-1];
         end
         r[k] = t;
      end
      return r;
   endfunction

   localparam rom_type TANH_ROM = build_rom();

   // stage 0: magnitude above the knee
   logic [MAG_W-1:0]        abs_x;
   logic [MAG_W:0]          diff_x;
   logic [MAG_W-1:0]        dmag0_ff;
   logic                    lim0_ff;
   logic                    neg0_ff;
   logic [SAMPLE_OUT_W-1:0] xlo0_ff;

   always_comb begin
      abs_x  = sample_in[SAMPLE_IN_W-1] ? MAG_W'(~sample_in + 1'b1) : MAG_W'(sample_in);
      diff_x = {1'b0, abs_x} - (MAG_W + 1)'(knee_threshold);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         dmag0_ff <= diff_x[MAG_W-1:0];
         lim0_ff  <= !diff_x[MAG_W] && (diff_x != '0);
         neg0_ff  <= sample_in[SAMPLE_IN_W-1];
         xlo0_ff  <= sample_in[SAMPLE_OUT_W-1:0];
      end
   end

   // stage 1: scale by the knee gain
   logic [PROD_W-1:0]       gprod;
   logic [ARG_W-1:0]        arg1_ff;
   logic                    lim1_ff;
   logic                    neg1_ff;
   logic [SAMPLE_OUT_W-1:0] xlo1_ff;

   assign gprod = PROD_W'(dmag0_ff) * PROD_W'(knee_gain);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         arg1_ff <= gprod[PROD_W-1:GAIN_FRAC_W];
         lim1_ff <= lim0_ff;
         neg1_ff <= neg0_ff;
         xlo1_ff <= xlo0_ff;
      end
   end

   // stage 2: table position, clamp past the last interval
   logic [P_W-1:0]          pos;
   logic [IDX_W-1:0]        idx;
   logic                    over;
   logic [AW-1:0]           addr_a2_ff;
   logic [AW-1:0]           addr_b2_ff;
   logic [FRAC_W-1:0]       frac2_ff;
   logic                    lim2_ff;
   logic                    neg2_ff;
   logic [SAMPLE_OUT_W-1:0] xlo2_ff;

   always_comb begin
      pos  = P_W'(arg1_ff) * P_W'(TANH_TABLE_ENTRIES);
      idx  = pos[P_W-1:FRAC_W];
      over = idx >= IDX_W'(TANH_TABLE_ENTRIES);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         addr_a2_ff <= over ? AW'(TANH_TABLE_ENTRIES) : idx[AW-1:0];
         addr_b2_ff <= over ? AW'(TANH_TABLE_ENTRIES) : AW'(idx[AW-1:0] + 1'b1);
         frac2_ff   <= pos[FRAC_W-1:0];
         lim2_ff    <= lim1_ff;
         neg2_ff    <= neg1_ff;
         xlo2_ff    <= xlo1_ff;
      end
   end

   // stage 3: table read, both interval ends
   logic [ROM_W-1:0]        a3_ff;
   logic [ROM_W-1:0]        b3_ff;
   logic [FRAC_W-1:0]       frac3_ff;
   logic                    lim3_ff;
   logic                    neg3_ff;
   logic [SAMPLE_OUT_W-1:0] xlo3_ff;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         a3_ff    <= TANH_ROM[addr_a2_ff];
         b3_ff    <= TANH_ROM[addr_b2_ff];
         frac3_ff <= frac2_ff;
         lim3_ff  <= lim2_ff;
         neg3_ff  <= neg2_ff;
         xlo3_ff  <= xlo2_ff;
      end
   end

   // stage 4: slope times fraction
   logic [ROM_W-1:0]        slope;
   logic [IP_W-1:0]         ip4_ff;
   logic [ROM_W-1:0]        a4_ff;
   logic                    lim4_ff;
   logic                    neg4_ff;
   logic [SAMPLE_OUT_W-1:0] xlo4_ff;

   assign slope = b3_ff - a3_ff;

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         ip4_ff  <= IP_W'(slope) * IP_W'(frac3_ff);
         a4_ff   <= a3_ff;
         lim4_ff <= lim3_ff;
         neg4_ff <= neg3_ff;
         xlo4_ff <= xlo3_ff;
      end
   end

   // stage 5: round and add to the lower end
   logic [IP_W:0]           ip_rnd;
   logic [ROM_W:0]          t_sum;
   logic [ROM_W-1:0]        t5_ff;
   logic                    lim5_ff;
   logic                    neg5_ff;
   logic [SAMPLE_OUT_W-1:0] xlo5_ff;

   always_comb begin
      ip_rnd = (IP_W + 1)'(ip4_ff) + ((IP_W + 1)'(1) << (FRAC_W - 1));
      t_sum  = (ROM_W + 1)'(a4_ff) + (ROM_W + 1)'(ip_rnd[IP_W:FRAC_W]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         t5_ff   <= t_sum[ROM_W-1:0];
         lim5_ff <= lim4_ff;
         neg5_ff <= neg4_ff;
         xlo5_ff <= xlo4_ff;
      end
   end

   // stage 6: headroom above the knee times tanh
   logic [ROM_W-1:0]        headroom;
   logic [2*ROM_W-1:0]      soft6_ff;
   logic                    lim6_ff;
   logic                    neg6_ff;
   logic [SAMPLE_OUT_W-1:0] xlo6_ff;

   assign headroom = ROM_W'(17'd32768 - 17'(knee_threshold));

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         soft6_ff <= (2*ROM_W)'(headroom) * (2*ROM_W)'(t5_ff);
         lim6_ff  <= lim5_ff;
         neg6_ff  <= neg5_ff;
         xlo6_ff  <= xlo5_ff;
      end
   end

   // final: add knee, saturate, restore sign; the merge stage registers this
   logic [2*ROM_W:0]        soft_rnd;
   logic [ROM_W+1:0]        knee_sum;
   logic [THR_W-1:0]        mag;
   logic [SAMPLE_OUT_W-1:0] mag_ext;

   always_comb begin
      soft_rnd   = (2*ROM_W + 1)'(soft6_ff) + ((2*ROM_W + 1)'(1) << 14);
      knee_sum   = (ROM_W + 2)'(knee_threshold) + (ROM_W + 2)'(soft_rnd[2*ROM_W:15]);
      mag        = (knee_sum > (ROM_W + 2)'(32767)) ? {THR_W{1'b1}} : knee_sum[THR_W-1:0];
      mag_ext    = {1'b0, mag};
      if (!lim6_ff) begin
         sample_out = xlo6_ff;
      end else if (neg6_ff) begin
         sample_out = -mag_ext;
      end else begin
         sample_out = mag_ext;
      end
      limited = lim6_ff;
   end

endmodule

/* rtl/core/stereo_tanh_soft_limiter_unit.sv */
// Top level of the stereo tanh soft limiter: config registers, stage control, lanes, merge.
//
//   channel  ports                                   direction  beat
//   req      req_valid/req_ready, req_left_in,       in         one stereo pair
//            req_right_in
//   rsp      rsp_valid/rsp_ready, rsp_left_out,      out        one limited pair + flags
//            rsp_right_out, rsp_*_limited
//   csr      csr_wr_en, csr_index, csr_wdata         in         one register write
//
// One pair per cycle sustained while rsp_ready is high; from req to rsp, one register each
// for the knee test, gain multiply, table position, table read, slope multiply,
// interpolation add, headroom multiply and the merge stage.
// Each lane reads its tanh table at two addresses per cycle.
// Reset clears all stage valids and loads the default knee threshold and gain.
// Each stage advances when it is empty or the stage after it advances, so a stalled
// rsp beat leaves req open until every bubble in the pipe has filled.
`timescale 1ns / 1ps

module stereo_tanh_soft_limiter_unit import stlim_pkg::*; #(
   parameter int unsigned TANH_TABLE_ENTRIES = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_IN_W-1:0]  req_left_in,
   input  logic signed [SAMPLE_IN_W-1:0]  req_right_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_OUT_W-1:0] rsp_left_out,
   output logic signed [SAMPLE_OUT_W-1:0] rsp_right_out,
   output logic                           rsp_left_limited,
   output logic                           rsp_right_limited,
   input  logic                           csr_wr_en,
   input  logic        [CSR_IDX_W-1:0]    csr_index,
   input  logic        [CSR_DATA_W-1:0]   csr_wdata
);

   // configuration registers
   logic [THR_W-1:0]  knee_threshold_ff;
   logic [GAIN_W-1:0] knee_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         knee_threshold_ff <= THR_RESET;
         knee_gain_ff      <= GAIN_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KNEE_THRESHOLD: knee_threshold_ff <= csr_wdata[THR_W-1:0];
            CSR_KNEE_GAIN:      knee_gain_ff      <= csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // stage valids and enables; the last stage is the rsp register
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] stage_adv;
   stage_en_type          lane_en;

   always_comb begin
      stage_adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ready;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         stage_adv[s] = !vld_ff[s] || stage_adv[s+1];
      end
      for (int s = 0; s < NUM_STAGES; s++) begin
         if (!stage_adv[s]) begin
            vld_in[s] = vld_ff[s];
         end else if (s == 0) begin
            vld_in[s] = req_valid;
         end else begin
            vld_in[s] = vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign lane_en   = stage_adv[LANE_STAGES-1:0];
   assign req_ready = stage_adv[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   // lanes: left is lane 0, right is lane 1
   logic signed [SAMPLE_IN_W-1:0]  lane_x   [NUM_LANES];
   logic signed [SAMPLE_OUT_W-1:0] lane_y   [NUM_LANES];
   logic                           lane_lim [NUM_LANES];

   assign lane_x[0] = req_left_in;
   assign lane_x[1] = req_right_in;

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      stlim_lane #(
         .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES)
      ) u_lane (
         .clock          (clock),
         .stage_en       (lane_en),
         .knee_threshold (knee_threshold_ff),
         .knee_gain      (knee_gain_ff),
         .sample_in      (lane_x[g]),
         .sample_out     (lane_y[g]),
         .limited        (lane_lim[g])
      );
   end

   // merge stage: hold both lane results as one rsp beat
   logic signed [SAMPLE_OUT_W-1:0] left_out_ff;
   logic signed [SAMPLE_OUT_W-1:0] right_out_ff;
   logic                           left_lim_ff;
   logic                           right_lim_ff;

   always_ff @(posedge clock) begin
      if (stage_adv[NUM_STAGES-1]) begin
         left_out_ff  <= lane_y[0];
         right_out_ff <= lane_y[1];
         left_lim_ff  <= lane_lim[0];
         right_lim_ff <= lane_lim[1];
      end
   end

   assign rsp_left_out      = left_out_ff;
   assign rsp_right_out     = right_out_ff;
   assign rsp_left_limited  = left_lim_ff;
   assign rsp_right_limited = right_lim_ff;

endmodule

/* verif/stereo_tanh_soft_limiter_unit_tb.sv */
// Testbench for the stereo tanh soft limiter: directed knee cases, random knees and streaming.
`timescale 1ns / 1ps

module stereo_tanh_soft_limiter_unit_tb import stlim_pkg::*;;

   localparam int unsigned TANH_ENTRIES = 256;
   localparam logic [14:0] DEFAULT_THR  = 15'd27886;
   localparam logic [15:0] DEFAULT_GAIN = 16'd27492;
   localparam bit [63:0]   ONE_Q30      = 64'd1 << 30;
   localparam int          DRAIN_CYCLES = 16;

   typedef struct packed {
      logic signed [15:0] value;
      logic               limited;
   } channel_out_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic               left_limited;
      logic               right_limited;
   } stereo_out_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [SAMPLE_IN_W-1:0]  req_left_in = '0;
   logic signed [SAMPLE_IN_W-1:0]  req_right_in = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic signed [SAMPLE_OUT_W-1:0] rsp_left_out;
   logic signed [SAMPLE_OUT_W-1:0] rsp_right_out;
   logic                           rsp_left_limited;
   logic                           rsp_right_limited;
   logic                           csr_wr_en = 1'b0;
   logic        [CSR_IDX_W-1:0]    csr_index = '0;
   logic        [CSR_DATA_W-1:0]   csr_wdata = '0;

   bit [63:0]      tanh_q15 [0:TANH_ENTRIES];
   logic [14:0]    knee_thr = DEFAULT_THR;
   logic [15:0]    knee_gain_q12 = DEFAULT_GAIN;
   stereo_out_type pending_pairs [$];
   int             mismatch_count = 0;
   bit             idle_on = 1'b0;
   int             stall_left = 0;

   stereo_tanh_soft_limiter_unit #(
      .TANH_TABLE_ENTRIES(TANH_ENTRIES)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_left_in       (req_left_in),
      .req_right_in      (req_right_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_out      (rsp_left_out),
      .rsp_right_out     (rsp_right_out),
      .rsp_left_limited  (rsp_left_limited),
      .rsp_right_limited (rsp_right_limited),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // exp(-y) in Q30: series on y/256, then square eight times
   function automatic bit [63:0] decay_q30(input bit [63:0] y);
      bit [63:0] z, z2, z3, z4, e;
      z  = y >> 8;
      z2 = (z * z) >> 30;
      z3 = (z2 * z) >> 30;
      z4 = (z2 * z2) >> 30;
      e  = ONE_Q30 + z2 / 64'd2 + z4 / 64'd24 - z - z3 / 64'd6;
      for (int s = 0; s < 8; s++)
         e = (e * e + (64'd1 << 29)) >> 30;
      return e;
   endfunction

   function automatic void fill_tanh_q15();
      bit [63:0] y, e, num, den, t;
      for (int k = 0; k <= TANH_ENTRIES; k++) begin
         y = ((64'd16 * k) << 30) / TANH_ENTRIES;
         e = decay_q30(y);
         if (e > ONE_Q30)
            e = ONE_Q30;
         num = (ONE_Q30 - e) << 15;
         den = ONE_Q30 + e;
         t   = (num + den / 64'd2) / den;
         if (t > 64'd32768)
            t = 64'd32768;
         // keep the table monotonic
         if (k > 0 && t < tanh_q15[k-1])
            t = tanh_q15[k-1];
         tanh_q15[k] = t;
      end
   endfunction

   function automatic channel_out_type limit_channel(input logic signed [17:0] x);
      channel_out_type o;
      bit [63:0] ax, arg, p, idx, frac, t, a, b, lim_mag;
      ax = x[17] ? 64'(-32'(x)) : 64'(32'(x));
      o.value   = x[15:0];
      o.limited = 1'b0;
      if (ax <= 64'(knee_thr))
         return o;
      o.limited = 1'b1;
      arg  = ((ax - 64'(knee_thr)) * 64'(knee_gain_q12)) >> 12;
      p    = arg * TANH_ENTRIES;
      idx  = p >> 18;
      frac = p & ((64'd1 << 18) - 1);
      if (idx >= TANH_ENTRIES) begin
         t = tanh_q15[TANH_ENTRIES];
      end else begin
         a = tanh_q15[idx];
         b = tanh_q15[idx + 1];
         t = a + (((b - a) * frac + (64'd1 << 17)) >> 18);
      end
      lim_mag = 64'(knee_thr) + (((64'd32768 - 64'(knee_thr)) * t + (64'd1 << 14)) >> 15);
      if (lim_mag > 64'd32767)
         lim_mag = 64'd32767;
      o.value = x[17] ? -lim_mag[15:0] : lim_mag[15:0];
      return o;
   endfunction

   function automatic stereo_out_type limit_pair(input logic signed [17:0] l,
                                                 input logic signed [17:0] r);
      stereo_out_type  s;
      channel_out_type lo, ro;
      lo = limit_channel(l);
      ro = limit_channel(r);
      s.left_out      = lo.value;
      s.right_out     = ro.value;
      s.left_limited  = lo.limited;
      s.right_limited = ro.limited;
      return s;
   endfunction

   // gain that software would load for a threshold: 1/(1-thr) in Q4.12
   function automatic logic [15:0] gain_for_knee(input logic [14:0] thr);
      bit [63:0] g;
      g = (64'd32768 * 64'd4096 + (64'd32768 - thr) / 2) / (64'd32768 - thr);
      if (g > 64'd65535)
         g = 64'd65535;
      return g[15:0];
   endfunction

   function automatic logic signed [17:0] pick_sample();
      int mag;
      logic signed [17:0] s;
      case ($urandom_range(0, 6))
         0, 1: s = 18'($urandom());
         2: begin
            mag = int'(knee_thr) + int'($urandom_range(0, 64)) - 32;
            if (mag < 0)
               mag = 0;
            s = 18'(mag);
         end
         3: s = 18'($urandom_range(0, knee_thr));
         4: s = 18'(int'(knee_thr) + int'($urandom_range(0, 3 * 32768)));
         5: s = 18'($urandom_range(0, 40));
         default: begin
            case ($urandom_range(0, 3))
               0:       s = 18'sd131071;
               1:       s = -18'sd131072;
               2:       s = 18'sd32767;
               default: s = 18'sd32768;
            endcase
         end
      endcase
      if ($urandom_range(0, 1))
         s = -s;
      return s;
   endfunction

   // receiver: hold ready low in bursts while idling is on
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      stereo_out_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.left_out      = rsp_left_out;
         got.right_out     = rsp_right_out;
         got.left_limited  = rsp_left_limited;
         got.right_limited = rsp_right_limited;
         if (pending_pairs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result beat with no pair pending: L=%0d R=%0d lim=%b%b",
                        $time, got.left_out, got.right_out,
                        got.left_limited, got.right_limited);
         end else begin
            want = pending_pairs.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: mismatch: expected L=%0d R=%0d lim=%b%b, got L=%0d R=%0d lim=%b%b",
                           $time, want.left_out, want.right_out, want.left_limited,
                           want.right_limited, got.left_out, got.right_out,
                           got.left_limited, got.right_limited);
            end
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_pair(input logic signed [17:0] l, input logic signed [17:0] r);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_left_in  <= l;
      req_right_in <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pending_pairs.push_back(limit_pair(l, r));
      @(negedge clock);
   endtask

   task automatic drain_pairs();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_knee(input logic [15:0] thr_word, input logic [15:0] gain_word);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_KNEE_THRESHOLD;
      csr_wdata <= thr_word;
      @(negedge clock);
      csr_index <= CSR_KNEE_GAIN;
      csr_wdata <= gain_word;
      @(negedge clock);
      csr_wr_en     <= 1'b0;
      knee_thr      = thr_word[14:0];
      knee_gain_q12 = gain_word;
   endtask

   // reset knee: pass-through edge, just above it, full-scale and past the table end
   task automatic test_default_knee();
      idle_on = 1'b1;
      send_pair(18'sd0, 18'sd0);
      send_pair(18'sd27886, -18'sd27886);
      send_pair(18'sd27887, -18'sd27887);
      send_pair(18'sd131071, -18'sd131072);
      send_pair(18'sd32767, -18'sd32768);
      send_pair(18'sd1, -18'sd1);
      send_pair(18'sd40000, -18'sd60000);
      drain_pairs();
   endtask

   // zero gain: limited samples land exactly on the knee
   task automatic test_zero_gain();
      set_knee(16'd16384, 16'd0);
      send_pair(18'sd16385, -18'sd16385);
      send_pair(18'sd131071, -18'sd131072);
      send_pair(18'sd16384, -18'sd16384);
      drain_pairs();
   endtask

   // knee at both ends: every nonzero sample limited, then saturation against full scale
   task automatic test_extreme_knees();
      set_knee(16'h0000, 16'hFFFF);
      send_pair(18'sd0, 18'sd1);
      send_pair(-18'sd1, 18'sd131071);
      send_pair(-18'sd131072, 18'sd300);
      drain_pairs();
      set_knee(16'hFFFF, 16'hFFFF);
      send_pair(18'sd32768, -18'sd32768);
      send_pair(18'sd32767, -18'sd32767);
      send_pair(18'sd131071, -18'sd131072);
      drain_pairs();
      set_knee(16'h7FFF, 16'd1);
      send_pair(18'sd32768, -18'sd40000);
      drain_pairs();
   endtask

   task automatic test_random_knees();
      logic [15:0] thr_word, gain_word;
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0:       thr_word = 16'd0;
            1:       thr_word = 16'd32767;
            default: thr_word = 16'($urandom_range(0, 32767));
         endcase
         gain_word = gain_for_knee(thr_word[14:0]);
         if (phase == 6)
            gain_word = 16'($urandom());
         // the threshold register is 15 bits; the top data bit must be dropped
         thr_word[15] = $urandom_range(0, 1);
         set_knee(thr_word, gain_word);
         idle_on = 1'b1;
         for (int i = 0; i < 48; i++)
            send_pair(pick_sample(), pick_sample());
         drain_pairs();
      end
   endtask

   task automatic test_streaming();
      set_knee(16'd24000, gain_for_knee(15'd24000));
      idle_on = 1'b0;
      for (int i = 0; i < 70; i++)
         send_pair(pick_sample(), pick_sample());
      drain_pairs();
   endtask

   initial begin
      fill_tanh_q15();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_knee();
      test_zero_gain();
      test_extreme_knees();
      test_random_knees();
      test_streaming();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_pairs.size() == 0) begin
         $display("** stereo_tanh_soft_limiter_unit: PASSED **");
      end else begin
         $display("** stereo_tanh_soft_limiter_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("** stereo_tanh_soft_limiter_unit: FAILED **");
      $finish;
   end

endmodule
